>>> sv/pnz_pkg.sv
// Shared constants and arithmetic helpers for the 3D noise unit.
package pnz_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int PERM_W     = 8;
  localparam int ONE_Q16    = 65536;

  // beat kinds on the input channel
  localparam logic MODE_EVAL = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef logic signed [16:0] offs_t;   // corner offset, signed Q0.16
  typedef logic signed [18:0] grad_t;   // gradient dot product
  typedef logic signed [17:0] wgt_t;    // faded weight
  typedef logic signed [23:0] blend_t;  // blend value

  localparam logic [3:0] H_SPLIT_U = 4'd8;
  localparam logic [3:0] H_SPLIT_V = 4'd4;
  localparam logic [3:0] H_X_A     = 4'd12;
  localparam logic [3:0] H_X_B     = 4'd14;

  // Pick one of the twelve gradient directions from the low hash bits.
  function automatic grad_t grad(input logic [PERM_W-1:0] hash,
                                 input offs_t x, input offs_t y, input offs_t z);
    logic [3:0] h;
    grad_t uu;
    grad_t vv;
    h  = hash[3:0];
    uu = (h < H_SPLIT_U) ? grad_t'(x) : grad_t'(y);
    if (h < H_SPLIT_V) begin
      vv = grad_t'(y);
    end else if (h == H_X_A || h == H_X_B) begin
      vv = grad_t'(x);
    end else begin
      vv = grad_t'(z);
    end
    if (h[0]) uu = -uu;
    if (h[1]) vv = -vv;
    return uu + vv;
  endfunction

  // a + floor((b - a) * w / 2^16)
  function automatic blend_t lerp(input wgt_t w, input blend_t a, input blend_t b);
    logic signed [24:0] diff;
    logic signed [42:0] prod;
    diff = 25'(b) - 25'(a);
    prod = 43'(diff) * 43'(w);
    return a + blend_t'(prod[42:16]);
  endfunction

endpackage

>>> sv/perlin_noise_3d_unit.sv
// Top level of the pipelined 3D improved-noise evaluator.
//
//   channel  signals                                           role
//   in       in_valid/in_ready, mode, perm_index, perm_value,  load or evaluate beat
//            coord_x, coord_y, coord_z
//   out      out_valid/out_ready, noise_value                  one beat per evaluation
//
// One beat enters per cycle while the output is not stalled; an evaluation passes
// through the scale multiplier, three table lookups, the fade chain of four
// multiplies and three blend levels. A load beat travels down the pipe
// and writes each table copy at the stage where that copy is read, so every
// evaluation sees the table as it stood when the evaluation was accepted. A
// load leaves no result. Reset clears the valid bits only; the table holds
// garbage until loaded and needs no clearing pass.
// A stall at the output freezes every stage, so nothing is lost or repeated.
module perlin_noise_3d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [7:0]                        perm_index,
  input  logic [7:0]                        perm_value,
  input  logic signed [31:0]                coord_x,
  input  logic signed [31:0]                coord_y,
  input  logic signed [31:0]                coord_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       noise_value
);

  localparam int AW = pnz_pkg::ADDR_W;
  localparam int PW = pnz_pkg::PERM_W;
  localparam int NSTAGE = 10;
  localparam int LSTAGE = 5;

  logic en;
  logic accept;
  logic load_we;
  logic eval_in;
  logic [NSTAGE-1:0] vld;
  logic [LSTAGE-1:0] ld_vld;
  logic [AW-1:0]     ld_idx [LSTAGE];
  logic [PW-1:0]     ld_val [LSTAGE];
  logic              we_x, we_ab, we_h;

  // Advance the whole pipe whenever the output register can move.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;
  assign load_we  = accept && (mode == pnz_pkg::MODE_LOAD);
  assign eval_in  = accept && (mode == pnz_pkg::MODE_EVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      ld_vld    <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NSTAGE-2:0], eval_in};
      ld_vld    <= {ld_vld[LSTAGE-2:0], load_we};
      out_valid <= vld[NSTAGE-1];
    end
  end

  // Carry load beats along so each copy is written in pipeline order.
  always_ff @(posedge clk) begin
    if (en) begin
      ld_idx[0] <= AW'(perm_index);
      ld_val[0] <= PW'(perm_value);
      for (int k = 1; k < LSTAGE; k++) begin
        ld_idx[k] <= ld_idx[k-1];
        ld_val[k] <= ld_val[k-1];
      end
    end
  end

  // the first lookup copy is read before the second, the second before the third
  assign we_x  = en && ld_vld[2];
  assign we_ab = en && ld_vld[3];
  assign we_h  = en && ld_vld[4];

  // ---- scale: x and y divided by 20, z delayed to match ----
  logic signed [31:0] xs [3];
  logic signed [31:0] z_d1;
  logic signed [31:0] z_d2;

  pnz_scale u_scale_x (.clk(clk), .en(en), .coord(coord_x), .scaled(xs[0]));
  pnz_scale u_scale_y (.clk(clk), .en(en), .coord(coord_y), .scaled(xs[1]));

  always_ff @(posedge clk) begin
    if (en) begin
      z_d1 <= coord_z;
      z_d2 <= z_d1;
    end
  end
  assign xs[2] = z_d2;

  // ---- split into lattice cell and Q0.16 fraction ----
  logic [AW-1:0] cell_c [3];
  logic [15:0]   frac_c [3];

  for (genvar k = 0; k < 3; k++) begin : g_split
    assign cell_c[k] = xs[k][FRAC_BITS +: AW];
    if (FRAC_BITS >= 16) begin : g_trunc
      assign frac_c[k] = xs[k][FRAC_BITS-1 -: 16];
    end else begin : g_pad
      assign frac_c[k] = {xs[k][FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    end
  end

  // Stage C
  logic [AW-1:0] c_xc, c_yc, c_zc;
  logic [15:0]   c_fx, c_fy, c_fz;
  // Stage D
  logic [AW-1:0] d_yc, d_zc;
  logic [15:0]   d_fx, d_fy, d_fz;
  // Stage E
  logic [AW-1:0] e_zc;
  logic [15:0]   e_fx, e_fy, e_fz;
  // Stage F
  logic [15:0]   f_fx, f_fy, f_fz;

  always_ff @(posedge clk) begin
    if (en) begin
      c_xc <= cell_c[0];
      c_yc <= cell_c[1];
      c_zc <= cell_c[2];
      c_fx <= frac_c[0];
      c_fy <= frac_c[1];
      c_fz <= frac_c[2];
      d_yc <= c_yc;
      d_zc <= c_zc;
      d_fx <= c_fx;
      d_fy <= c_fy;
      d_fz <= c_fz;
      e_zc <= d_zc;
      e_fx <= d_fx;
      e_fy <= d_fy;
      e_fz <= d_fz;
      f_fx <= e_fx;
      f_fy <= e_fy;
      f_fz <= e_fz;
    end
  end

  // ---- hash: three lookup levels, one table copy per read pair ----
  logic [PW-1:0] p_x0, p_x1;
  logic [PW-1:0] p_a0, p_a1, p_b0, p_b1;
  logic [PW-1:0] h_aa0, h_aa1, h_ab0, h_ab1, h_ba0, h_ba1, h_bb0, h_bb1;
  logic [AW-1:0] addr_a, addr_b;
  logic [AW-1:0] addr_aa, addr_ab, addr_ba, addr_bb;

  assign addr_a  = AW'(p_x0) + d_yc;
  assign addr_b  = AW'(p_x1) + d_yc;
  assign addr_aa = AW'(p_a0) + e_zc;
  assign addr_ab = AW'(p_a1) + e_zc;
  assign addr_ba = AW'(p_b0) + e_zc;
  assign addr_bb = AW'(p_b1) + e_zc;

  pnz_perm_ram u_ram_x (.clk(clk), .en(en), .we(we_x), .waddr(ld_idx[2]),
    .wdata(ld_val[2]), .raddr(c_xc), .rdata0(p_x0), .rdata1(p_x1));
  pnz_perm_ram u_ram_a (.clk(clk), .en(en), .we(we_ab), .waddr(ld_idx[3]),
    .wdata(ld_val[3]), .raddr(addr_a), .rdata0(p_a0), .rdata1(p_a1));
  pnz_perm_ram u_ram_b (.clk(clk), .en(en), .we(we_ab), .waddr(ld_idx[3]),
    .wdata(ld_val[3]), .raddr(addr_b), .rdata0(p_b0), .rdata1(p_b1));
  pnz_perm_ram u_ram_aa (.clk(clk), .en(en), .we(we_h), .waddr(ld_idx[4]),
    .wdata(ld_val[4]), .raddr(addr_aa), .rdata0(h_aa0), .rdata1(h_aa1));
  pnz_perm_ram u_ram_ab (.clk(clk), .en(en), .we(we_h), .waddr(ld_idx[4]),
    .wdata(ld_val[4]), .raddr(addr_ab), .rdata0(h_ab0), .rdata1(h_ab1));
  pnz_perm_ram u_ram_ba (.clk(clk), .en(en), .we(we_h), .waddr(ld_idx[4]),
    .wdata(ld_val[4]), .raddr(addr_ba), .rdata0(h_ba0), .rdata1(h_ba1));
  pnz_perm_ram u_ram_bb (.clk(clk), .en(en), .we(we_h), .waddr(ld_idx[4]),
    .wdata(ld_val[4]), .raddr(addr_bb), .rdata0(h_bb0), .rdata1(h_bb1));

  // ---- fade runs alongside the lookups, lands at stage G ----
  pnz_pkg::wgt_t fu, fv, fw;

  pnz_fade u_fade_x (.clk(clk), .en(en), .t(c_fx), .fade(fu));
  pnz_fade u_fade_y (.clk(clk), .en(en), .t(c_fy), .fade(fv));
  pnz_fade u_fade_z (.clk(clk), .en(en), .t(c_fz), .fade(fw));

  // ---- gradients at the eight corners ----
  pnz_pkg::offs_t ox0, ox1, oy0, oy1, oz0, oz1;
  pnz_pkg::grad_t g [8];

  // far-corner offset f - 1.0 is the fraction with the sign bit set
  assign ox0 = $signed({1'b0, f_fx});
  assign ox1 = $signed({1'b1, f_fx});
  assign oy0 = $signed({1'b0, f_fy});
  assign oy1 = $signed({1'b1, f_fy});
  assign oz0 = $signed({1'b0, f_fz});
  assign oz1 = $signed({1'b1, f_fz});

  always_ff @(posedge clk) begin
    if (en) begin
      g[0] <= pnz_pkg::grad(h_aa0, ox0, oy0, oz0);
      g[1] <= pnz_pkg::grad(h_ba0, ox1, oy0, oz0);
      g[2] <= pnz_pkg::grad(h_ab0, ox0, oy1, oz0);
      g[3] <= pnz_pkg::grad(h_bb0, ox1, oy1, oz0);
      g[4] <= pnz_pkg::grad(h_aa1, ox0, oy0, oz1);
      g[5] <= pnz_pkg::grad(h_ba1, ox1, oy0, oz1);
      g[6] <= pnz_pkg::grad(h_ab1, ox0, oy1, oz1);
      g[7] <= pnz_pkg::grad(h_bb1, ox1, oy1, oz1);
    end
  end

  // ---- trilinear blend, one axis per stage ----
  pnz_pkg::blend_t l_u [4];
  pnz_pkg::blend_t l_v [2];
  pnz_pkg::blend_t r_w;
  pnz_pkg::wgt_t   h_fv, h_fw, i_fw;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        l_u[k] <= pnz_pkg::lerp(fu, pnz_pkg::blend_t'(g[2*k]),
                                pnz_pkg::blend_t'(g[2*k+1]));
      end
      h_fv   <= fv;
      h_fw   <= fw;
      l_v[0] <= pnz_pkg::lerp(h_fv, l_u[0], l_u[1]);
      l_v[1] <= pnz_pkg::lerp(h_fv, l_u[2], l_u[3]);
      i_fw   <= h_fw;
      r_w    <= pnz_pkg::lerp(i_fw, l_v[0], l_v[1]);
    end
  end

  // ---- map (r+1)/2 into 0..65535 ----
  logic signed [24:0] half;

  assign half = (25'(r_w) + 25'sd65536) >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      if (half < 25'sd0) begin
        noise_value <= 16'd0;
      end else if (half > 25'sd65535) begin
        noise_value <= 16'hFFFF;
      end else begin
        noise_value <= half[15:0];
      end
    end
  end

  // ---- checks ----
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    load_we |=> !vld[0])
    else $error("load beat entered the evaluation pipe");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[NSTAGE-1]))
    else $error("result appeared without a finished evaluation");

  a_eval_enters: assert property (@(posedge clk) disable iff (rst)
    eval_in |=> vld[0])
    else $error("evaluation beat dropped at entry");

endmodule

>>> sv/pnz_perm_ram.sv
// Permutation table copy: one write port, reads an entry and its successor.
module pnz_perm_ram (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic                                     we,
  input  logic [pnz_pkg::ADDR_W-1:0]               waddr,
  input  logic [pnz_pkg::PERM_W-1:0]               wdata,
  input  logic [pnz_pkg::ADDR_W-1:0]               raddr,
  output logic [pnz_pkg::PERM_W-1:0]               rdata0,
  output logic [pnz_pkg::PERM_W-1:0]               rdata1
);

  logic [pnz_pkg::PERM_W-1:0] mem [pnz_pkg::TABLE_SIZE];
  logic [pnz_pkg::ADDR_W-1:0] raddr_inc;

  // successor wraps around the table
  assign raddr_inc = raddr + pnz_pkg::ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata0 <= mem[raddr];
      rdata1 <= mem[raddr_inc];
    end
  end

endmodule

>>> sv/pnz_scale.sv
// Floor division of a signed coordinate by 20, two register stages.
module pnz_scale (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] coord,
  output logic signed [31:0] scaled
);

  // floor(v/20) = floor(floor(v/4)/5); bias by 5*2^27 to divide unsigned
  localparam logic signed [31:0] BIAS  = 32'sd671088640;
  localparam logic        [31:0] RECIP = 32'hCCCCCCCD;
  localparam logic        [31:0] QBIAS = 32'd134217728;

  logic signed [31:0] biased;
  logic        [30:0] num;
  logic        [62:0] prod;

  assign biased = (coord >>> 2) + BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      num  <= biased[30:0];
      prod <= 63'(num) * 63'(RECIP);
    end
  end

  assign scaled = $signed({3'b000, prod[62:34]} - QBIAS);

endmodule

>>> sv/pnz_fade.sv
// Quintic fade 6t^5-15t^4+10t^3 in Q0.16, four multiply stages.
module pnz_fade (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          t,
  output pnz_pkg::wgt_t        fade
);

  localparam logic signed [21:0] FIFTEEN = 22'sd983040;
  localparam logic signed [23:0] TEN     = 24'sd655360;

  logic signed [21:0] a_c;
  logic signed [23:0] b_c;
  logic signed [24:0] c_c;
  logic signed [25:0] d_c;
  logic signed [38:0] p1;
  logic signed [40:0] p2;
  logic signed [41:0] p3;
  logic signed [42:0] p4;
  logic [15:0] t1;
  logic [15:0] t2;
  logic [15:0] t3;

  assign a_c = 22'sd6 * $signed({6'b000000, t}) - FIFTEEN;
  assign b_c = $signed(p1[38:16]) + TEN;
  assign c_c = $signed(p2[40:16]);
  assign d_c = $signed(p3[41:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= 39'(a_c) * $signed({23'd0, t});
      t1 <= t;
      p2 <= 41'(b_c) * $signed({25'd0, t1});
      t2 <= t1;
      p3 <= 42'(c_c) * $signed({26'd0, t2});
      t3 <= t2;
      p4 <= 43'(d_c) * $signed({27'd0, t3});
    end
  end

  assign fade = pnz_pkg::wgt_t'(p4[42:16]);

endmodule
